// ----- rtl/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the profile linear interpolator: operation
// codes, field widths and the stored table point.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int unsigned OpW  = 2;
  localparam int unsigned DatW = 32;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // One table entry: height and value, both signed Q16.16.
  typedef struct packed {
    logic signed [DatW-1:0] height;
    logic signed [DatW-1:0] value;
  } point_t;

  localparam logic [DatW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [DatW-1:0] SatMin = 32'h8000_0000;

endpackage

// ----- rtl/pli_point_mem.sv -----
// ----------------------------------------------------------------------------
// pli_point_mem
// Point table storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module pli_point_mem
  import pli_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  point_t           wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output point_t           rdata_o
);

  point_t mem [Depth];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/profile_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// profile_linear_interpolator
// Piecewise linear interpolation over a loaded table of (height, value)
// points, with endpoint clamping and a saturating fixed-point divide.
// ----------------------------------------------------------------------------
// Usage:
// Input beats carry an operation in tuser and a height and value in tdata.
// A clear empties the table and rewinds the cursor; an append stores one
// point (dropped when the table is full). Neither gives an output beat.
// A query gives exactly one output beat carrying the result
// value and the clamped, empty and saturated flags.
// A query walks the table one cursor advance per step, each step comparing
// against one memory read. An empty table skips the walk; a clamped result
// comes from the walk or a zero height span; a clip is caught by a check
// before the divide; an interpolated result takes two products and 32 divide steps.
// tready is high only while the sequencer is idle. The result sits in an
// output register, so a new beat is taken while it waits for the receiver;
// a second result waits in the sequencer until the register frees up.
// Reset empties the table and rewinds the cursor; no memory sweep is needed.
// ----------------------------------------------------------------------------
module profile_linear_interpolator
  import pli_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // [31:0] height, [63:32] value
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] result_value
  output logic [2:0]  m_axis_tuser_o   // [0] clamped, [1] empty_table, [2] saturated
);

  localparam int unsigned IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned StepW = $clog2(DatW);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_PREV,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_CHK,
    ST_DIV,
    ST_FIN,
    ST_RESULT
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  cursor_q, cursor_d;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  logic [DatW-1:0]  out_value_q;
  logic [2:0]       out_flags_q;

  // Datapath registers
  logic signed [DatW-1:0] t_q, hk_q, vk_q, vp_q;
  logic signed [64:0]     prod_q, acc_q;
  logic [65:0]            mnum_q;
  logic [DatW:0]          mden_q;
  logic                   den_neg_q, neg_q;
  logic [DatW:0]          rem_q;
  logic [DatW-1:0]        lo_q;
  logic [DatW-1:0]        res_value_q;
  logic [2:0]             res_flags_q;

  logic      in_fire, out_load, advance, mem_we;
  op_e       op;
  point_t    in_point, rd_point;
  logic [IdxW-1:0] raddr;

  assign op              = op_e'(s_axis_tuser_i);
  assign in_point.height = s_axis_tdata_i[31:0];
  assign in_point.value  = s_axis_tdata_i[63:32];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready_i);
  assign mem_we          = in_fire && (op == OP_APPEND) && (count_q < CntW'(MAX_POINTS));

  assign advance = (t_q > rd_point.height) && ((CntW'(cursor_q) + 1'b1) < count_q);

  // The point below the cursor stays on the read port until the first product.
  always_comb begin
    raddr = cursor_q;
    if (state_q == ST_WALK) begin
      raddr = advance ? cursor_q + 1'b1 : cursor_q - 1'b1;
    end else if (state_q == ST_PREV) begin
      raddr = cursor_q - 1'b1;
    end
  end

  pli_point_mem #(
    .Depth (MAX_POINTS),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (in_point),
    .raddr_i (raddr),
    .rdata_o (rd_point)
  );

  // Shared subtractor and multiplier, steered by the sequencer.
  logic signed [DatW-1:0] sub_a, sub_b, mul_a;
  logic signed [DatW:0]   diff;
  logic signed [64:0]     mul_a_x, mul_b_x, prod;

  always_comb begin
    sub_a = hk_q;
    sub_b = rd_point.height;
    mul_a = vp_q;
    unique case (state_q)
      ST_MUL_A: begin
        sub_a = t_q;
        sub_b = rd_point.height;
        mul_a = vk_q;
      end
      ST_MUL_B: begin
        sub_a = hk_q;
        sub_b = t_q;
        mul_a = vp_q;
      end
      default: begin
        sub_a = hk_q;
        sub_b = rd_point.height;
        mul_a = vp_q;
      end
    endcase
  end

  assign diff    = {sub_a[DatW-1], sub_a} - {sub_b[DatW-1], sub_b};
  assign mul_a_x = 65'(mul_a);
  assign mul_b_x = 65'(diff);
  assign prod    = mul_a_x * mul_b_x;

  logic signed [65:0] num;
  logic [34:0]        trial;
  logic [33:0]        shifted;

  assign num     = {acc_q[64], acc_q} + {prod_q[64], prod_q};
  assign shifted = {rem_q, lo_q[DatW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, mden_q};

  // Sequencer and control state
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_CLEAR: begin
              count_d  = '0;
              cursor_d = '0;
            end
            OP_APPEND: begin
              if (mem_we) count_d = count_q + 1'b1;
            end
            OP_QUERY: begin
              state_d = (count_q == '0) ? ST_RESULT : ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (advance) begin
          cursor_d = cursor_q + 1'b1;
        end else if (cursor_q == '0 || t_q >= rd_point.height) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_PREV;
        end
      end
      ST_PREV:  state_d = (diff == '0) ? ST_RESULT : ST_MUL_A;
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_SUM;
      ST_SUM:   state_d = ST_CHK;
      ST_CHK:   state_d = (mnum_q[65:32] >= {1'b0, mden_q}) ? ST_RESULT : ST_DIV;
      ST_DIV:   state_d = (step_q == StepW'(DatW - 1)) ? ST_FIN : ST_DIV;
      ST_FIN:   state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_DIV) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= res_value_q;
      out_flags_q <= res_flags_q;
    end
    case (state_q)
      ST_IDLE: begin
        t_q         <= in_point.height;
        res_value_q <= '0;
        res_flags_q <= 3'b010;
      end
      ST_WALK: begin
        // Read data holds the cursor point here.
        hk_q        <= rd_point.height;
        vk_q        <= rd_point.value;
        res_value_q <= rd_point.value;
        res_flags_q <= 3'b001;
      end
      ST_PREV: begin
        // Read data holds the point below the cursor; diff is the height span.
        den_neg_q   <= diff[DatW];
        mden_q      <= diff[DatW] ? -diff : diff;
        vp_q        <= rd_point.value;
        res_value_q <= vk_q;
        res_flags_q <= 3'b001;
      end
      ST_MUL_A: prod_q <= prod;
      ST_MUL_B: begin
        acc_q  <= prod_q;
        prod_q <= prod;
      end
      ST_SUM: begin
        mnum_q <= num[65] ? 66'(-num) : 66'(num);
        neg_q  <= num[65] ^ den_neg_q;
      end
      ST_CHK: begin
        // A quotient of 2^32 or more always clips.
        rem_q       <= mnum_q[64:32];
        lo_q        <= mnum_q[31:0];
        res_value_q <= neg_q ? SatMin : SatMax;
        res_flags_q <= 3'b100;
      end
      ST_DIV: begin
        if (!trial[34]) begin
          rem_q <= trial[32:0];
          lo_q  <= {lo_q[DatW-2:0], 1'b1};
        end else begin
          rem_q <= shifted[32:0];
          lo_q  <= {lo_q[DatW-2:0], 1'b0};
        end
      end
      ST_FIN: begin
        if (lo_q == '0) begin
          res_value_q <= '0;
          res_flags_q <= 3'b000;
        end else if (!neg_q && lo_q > SatMax) begin
          res_value_q <= SatMax;
          res_flags_q <= 3'b100;
        end else if (neg_q && lo_q > SatMin) begin
          res_value_q <= SatMin;
          res_flags_q <= 3'b100;
        end else begin
          res_value_q <= neg_q ? -lo_q : lo_q;
          res_flags_q <= 3'b000;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_flags_q;

endmodule

// ----- dv/tb_profile_linear_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_profile_linear_interpolator
// Self-checking bench for the profile linear interpolator. A queue of
// commands (clear, append, query) is driven into the input stream while a
// local copy of the table and cursor predicts every query result. The
// output stream is compared field by field against those predictions.
// Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_profile_linear_interpolator;
  import pli_pkg::*;

  localparam int MaxPts    = 64;
  localparam int CalmTail  = 60;   // no idling once this few commands remain
  localparam int LongAt    = 400;  // pending count at which the long hold starts
  localparam int LongHold  = 300;
  localparam int ItemGoal  = 650;
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam logic signed [71:0] QMax = 72'sd2147483647;
  localparam logic signed [71:0] QMin = -QMax - 72'sd1;

  typedef struct {
    logic [OpW-1:0]         op;
    logic signed [DatW-1:0] height;
    logic signed [DatW-1:0] value;
    bit                     settle;  // hold this beat until all results are in
  } cmd_t;

  typedef struct packed {
    logic signed [DatW-1:0] value;
    logic                   clamped;
    logic                   empty;
    logic                   sat;
  } lerp_res_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [63:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  cmd_t      cmd_q[$];
  lerp_res_t lerp_q[$];
  int        n_items = 0;
  int        n_err   = 0;
  bit        took    = 1'b0;

  // Local copy of the table and the cursor.
  logic signed [DatW-1:0] tbl_h [MaxPts];
  logic signed [DatW-1:0] tbl_v [MaxPts];
  int tbl_cnt = 0;
  int cur     = 0;

  int snd_gap = 0, snd_phase = 0, snd_rate = 0;
  int rcv_hold = 0, rcv_phase = 0, rcv_rate = 0;
  bit long_done = 1'b0;

  profile_linear_interpolator #(
    .MAX_POINTS(MaxPts)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  task automatic push_cmd(input logic [OpW-1:0] op, input logic signed [31:0] h,
                          input logic signed [31:0] v, input bit settle);
    cmd_t c;
    c.op = op;
    c.height = h;
    c.value = v;
    c.settle = settle;
    cmd_q.push_back(c);
    if (op != OpUnused) n_items++;
  endtask

  // Applies one accepted command to the local table and queues the result of a query.
  task automatic lerp_predict(input cmd_t c);
    logic signed [71:0] tt, hk, hp, vk, vp, num, den, quo;
    lerp_res_t r;
    r = '0;
    case (c.op)
      OP_CLEAR: begin
        tbl_cnt = 0;
        cur = 0;
      end
      OP_APPEND: begin
        if (tbl_cnt < MaxPts) begin
          tbl_h[tbl_cnt] = c.height;
          tbl_v[tbl_cnt] = c.value;
          tbl_cnt++;
        end
      end
      OP_QUERY: begin
        if (tbl_cnt == 0) begin
          r.empty = 1'b1;
        end else begin
          if (cur >= tbl_cnt) cur = tbl_cnt - 1;
          while (c.height > tbl_h[cur] && cur + 1 < tbl_cnt) cur++;
          if (cur == 0 || c.height >= tbl_h[cur]) begin
            r.value = tbl_v[cur];
            r.clamped = 1'b1;
          end else begin
            tt = c.height;
            hk = tbl_h[cur];
            hp = tbl_h[cur-1];
            vk = tbl_v[cur];
            vp = tbl_v[cur-1];
            den = hk - hp;
            if (den == 0) begin
              r.value = tbl_v[cur];
              r.clamped = 1'b1;
            end else begin
              // Exact at 72 bits; SV division truncates toward zero.
              num = vk * (tt - hp) + vp * (hk - tt);
              quo = num / den;
              if (quo > QMax) begin
                r.value = SatMax;
                r.sat = 1'b1;
              end else if (quo < QMin) begin
                r.value = SatMin;
                r.sat = 1'b1;
              end else begin
                r.value = quo[31:0];
              end
            end
          end
        end
        lerp_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Input acceptance and output checking, both on the rising edge.
  always @(posedge clk_i) begin
    lerp_res_t want;
    lerp_res_t seen;
    took <= s_valid && s_axis_tready_o;
    if (rst_ni && s_valid && s_axis_tready_o) begin
      lerp_predict(cmd_q[0]);
      cmd_q.delete(0);
    end
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      seen.value   = m_axis_tdata_o;
      seen.clamped = m_axis_tuser_o[0];
      seen.empty   = m_axis_tuser_o[1];
      seen.sat     = m_axis_tuser_o[2];
      if (lerp_q.size() == 0) begin
        $error("unexpected output beat: result_value %0d", seen.value);
        n_err++;
      end else begin
        want = lerp_q.pop_front();
        if (seen.value !== want.value) begin
          $error("result_value: expected %0d, got %0d", want.value, seen.value);
          n_err++;
        end
        if (seen.clamped !== want.clamped) begin
          $error("clamped: expected %0b, got %0b", want.clamped, seen.clamped);
          n_err++;
        end
        if (seen.empty !== want.empty) begin
          $error("empty_table: expected %0b, got %0b", want.empty, seen.empty);
          n_err++;
        end
        if (seen.sat !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, seen.sat);
          n_err++;
        end
      end
    end
  end

  // Sender: a new beat goes out only after the previous one was taken.
  always @(negedge clk_i) begin
    if (snd_phase == 0) begin
      snd_phase = $urandom_range(30, 200);
      snd_rate = $urandom_range(0, 3);
    end else begin
      snd_phase--;
    end
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || took) begin
      if (snd_gap > 0) begin
        snd_gap--;
        s_valid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        s_valid <= 1'b0;
      end else if (cmd_q[0].settle && lerp_q.size() != 0) begin
        s_valid <= 1'b0;
      end else if (cmd_q.size() >= CalmTail && $urandom_range(0, 9) < snd_rate) begin
        snd_gap = $urandom_range(0, 14);
        s_valid <= 1'b0;
      end else begin
        s_valid <= 1'b1;
        s_data <= {cmd_q[0].value, cmd_q[0].height};
        s_user <= cmd_q[0].op;
      end
    end
  end

  // Receiver: random stalls plus one long hold so the block backs up.
  always @(negedge clk_i) begin
    if (rcv_phase == 0) begin
      rcv_phase = $urandom_range(30, 200);
      rcv_rate = $urandom_range(0, 3);
    end else begin
      rcv_phase--;
    end
    if (rst_ni && !long_done && cmd_q.size() <= LongAt) begin
      long_done = 1'b1;
      rcv_hold = LongHold;
    end
    if (rcv_hold > 0) begin
      rcv_hold--;
      m_ready <= 1'b0;
    end else if (cmd_q.size() >= CalmTail && $urandom_range(0, 9) < rcv_rate) begin
      rcv_hold = $urandom_range(0, 14);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  initial begin
    int     n_seq, npts, nq, pick, i, j, waited;
    longint stride, hcur, hstart, tq, tstep;
    logic signed [31:0] vv;

    // Empty table, unused code, then a table spanning the full height range.
    push_cmd(OP_QUERY, 32'sd0, 32'sd0, 1'b0);
    push_cmd(OpUnused, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    push_cmd(OP_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    push_cmd(OP_QUERY, 32'sh7FFF_FFFF, 32'sd0, 1'b0);
    push_cmd(OP_APPEND, 32'sd0, 32'sh8000_0000, 1'b0);
    push_cmd(OP_APPEND, 32'sd0, 32'sh1234_5678, 1'b0);
    push_cmd(OP_APPEND, 32'sh7FFF_FFFF, -32'sd1, 1'b0);
    push_cmd(OP_QUERY, 32'sh8000_0000, 32'sd0, 1'b0);
    push_cmd(OP_QUERY, -32'sd100, 32'sd0, 1'b0);
    push_cmd(OP_QUERY, 32'sd0, 32'sd0, 1'b0);
    push_cmd(OP_QUERY, 32'sd1, 32'sd0, 1'b0);
    push_cmd(OP_QUERY, 32'sh7FFF_FFFF, 32'sd0, 1'b0);
    push_cmd(OP_QUERY, 32'sd5, 32'sd0, 1'b0);
    // Two points at the same height, reached by a query that steps back.
    push_cmd(OP_CLEAR, 32'sd0, 32'sd0, 1'b0);
    push_cmd(OP_APPEND, 32'sd10, 32'sd100, 1'b0);
    push_cmd(OP_APPEND, 32'sd10, 32'sd200, 1'b0);
    push_cmd(OP_QUERY, 32'sd50, 32'sd0, 1'b0);
    push_cmd(OP_QUERY, 32'sd5, 32'sd0, 1'b0);
    // Descending table: the quotient overflows high, then low.
    push_cmd(OP_CLEAR, 32'sd0, 32'sd0, 1'b0);
    push_cmd(OP_APPEND, 32'sd100, 32'sh8000_0000, 1'b0);
    push_cmd(OP_APPEND, 32'sd10, 32'sh7FFF_FFFF, 1'b0);
    push_cmd(OP_QUERY, 32'sd200, 32'sd0, 1'b0);
    push_cmd(OP_QUERY, 32'sd5, 32'sd0, 1'b0);
    push_cmd(OP_CLEAR, 32'sd0, 32'sd0, 1'b0);
    push_cmd(OP_APPEND, 32'sd100, 32'sh7FFF_FFFF, 1'b0);
    push_cmd(OP_APPEND, 32'sd10, 32'sh8000_0000, 1'b0);
    push_cmd(OP_QUERY, 32'sd200, 32'sd0, 1'b0);
    push_cmd(OP_QUERY, 32'sd5, 32'sd0, 1'b0);

    n_seq = 0;
    while (n_items < ItemGoal) begin
      n_seq++;
      if ($urandom_range(0, 99) < 80) begin
        // Well-formed profile: clear, ascending points, mostly rising queries.
        push_cmd(OP_CLEAR, $urandom, $urandom, (n_seq % 12) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 4) npts = $urandom_range(60, 70);
        else if (pick < 15) npts = $urandom_range(1, 3);
        else npts = $urandom_range(2, 10);
        case ($urandom_range(0, 2))
          0:       stride = 100;
          1:       stride = 64'd1 << 18;
          default: stride = 64'd1 << 27;
        endcase
        hcur = longint'(int'($urandom));
        if (stride > 100) hcur = hcur / 2;
        hstart = hcur;
        for (i = 0; i < npts; i++) begin
          if ($urandom_range(0, 2) == 0) vv = $urandom;
          else vv = int'($urandom_range(0, 1 << 21)) - (1 << 20);
          push_cmd(OP_APPEND, clip32(hcur), vv, 1'b0);
          if ($urandom_range(0, 9) != 0) hcur += longint'($urandom) % stride + 1;
        end
        nq = $urandom_range(3, 12);
        tstep = (hcur - hstart) * 2 / nq + 1;
        if (tstep > (64'd1 << 31)) tstep = 64'd1 << 31;
        tq = hstart - longint'($urandom) % stride;
        for (j = 0; j < nq; j++) begin
          if ($urandom_range(0, 6) == 0) push_cmd(OP_QUERY, $urandom, $urandom, 1'b0);
          else push_cmd(OP_QUERY, clip32(tq), $urandom, 1'b0);
          tq += longint'($urandom) % tstep;
        end
        if ($urandom_range(0, 5) == 0) begin
          push_cmd(OP_APPEND, clip32(hcur), $urandom, 1'b0);
          push_cmd(OP_QUERY, clip32(hcur - 1), $urandom, 1'b0);
        end
      end else begin
        // Noise: any code, unordered points, random targets.
        nq = $urandom_range(3, 8);
        for (j = 0; j < nq; j++) begin
          push_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, 1'b0);
        end
      end
    end

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0) @(posedge clk_i);
    waited = 0;
    while (lerp_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
    if (lerp_q.size() != 0) begin
      $error("%0d query results never arrived", lerp_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("[profile_linear_interpolator] OK");
    end else begin
      $display("[profile_linear_interpolator] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[profile_linear_interpolator] ERROR");
    $finish;
  end

endmodule
